// ===== src/qou_pkg.sv =====
// package: constants, kind codes and the mac control struct for the quaternion orientation unit
`default_nettype none
package qou_pkg;
  localparam int FRAC_BITS_DEF  = 14;
  localparam int COMP_WIDTH_DEF = 16;
  localparam int IN_BITS        = 16;
  localparam int OUT_BITS       = 16;
  localparam int KIND_BITS      = 2;

  typedef enum logic [1:0] {
    KIND_LOAD = 2'd0,
    KIND_MUL  = 2'd1,
    KIND_NORM = 2'd2,
    KIND_NOP  = 2'd3
  } kind_t;

  typedef struct packed {
    logic start;
    logic clear;
    logic sub;
  } mac_ctl_t;
endpackage
`default_nettype wire

// ===== src/qou_mac.sv =====
// shared multiply-accumulate unit: one signed product shifted and added or subtracted per cycle while start is high
`default_nettype none
module qou_mac #(
  parameter int FRAC_BITS  = qou_pkg::FRAC_BITS_DEF,
  parameter int COMP_WIDTH = qou_pkg::COMP_WIDTH_DEF,
  parameter int ACC_W      = 2 * COMP_WIDTH + 4
) (
  input  wire logic                          clk,
  input  wire qou_pkg::mac_ctl_t             ctl,
  input  wire logic signed [COMP_WIDTH-1:0]  a,
  input  wire logic signed [COMP_WIDTH-1:0]  b,
  output logic signed [ACC_W-1:0]            acc
);
  logic signed [2*COMP_WIDTH-1:0] prod;
  logic signed [ACC_W-1:0]        term;
  logic signed [ACC_W-1:0]        base;

  always_comb begin
    prod = a * b;
    term = ACC_W'(prod >>> FRAC_BITS);
    base = ctl.clear ? '0 : acc;
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      acc <= ctl.sub ? base - term : base + term;
    end
  end
endmodule
`default_nettype wire

// ===== src/qou_sqdiv.sv =====
// iterative unsigned square root and restoring divider, one bit per cycle while busy
`default_nettype none
module qou_sqdiv #(
  parameter int SW = 66,
  parameter int NW = 64,
  parameter int DW = 33
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          sqrt_go,
  input  wire logic [SW-1:0] s_in,
  input  wire logic          div_go,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  output logic               busy,
  output logic [DW-1:0]      root,
  output logic [NW-1:0]      quo
);
  localparam int RB  = (SW + 1) / 2;
  localparam int CW  = $clog2(NW + 1);
  logic [SW-1:0]   rem_s;
  logic [RB+1:0]   rem_r;
  logic [RB-1:0]   res;
  logic [DW:0]     dr;
  logic [CW-1:0]   cnt;
  logic            mode;
  logic [RB+1:0]   trial;
  logic [RB+1:0]   sh_r;
  logic [DW:0]     sh_d;

  always_comb begin
    sh_r  = {rem_r[RB-1:0], rem_s[SW-1 -: 2]};
    trial = {res, 2'b01};
    sh_d  = {dr[DW-1:0], quo[NW-1]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (sqrt_go) begin
      busy  <= 1'b1;
      mode  <= 1'b0;
      rem_s <= s_in;
      rem_r <= '0;
      res   <= '0;
      cnt   <= CW'(RB);
    end else if (div_go) begin
      busy <= 1'b1;
      mode <= 1'b1;
      quo  <= num;
      dr   <= '0;
      cnt  <= CW'(NW);
    end else if (busy) begin
      if (!mode) begin
        rem_s <= {rem_s[SW-3:0], 2'b00};
        if (sh_r >= trial) begin
          rem_r <= sh_r - trial;
          res   <= {res[RB-2:0], 1'b1};
        end else begin
          rem_r <= sh_r;
          res   <= {res[RB-2:0], 1'b0};
        end
      end else begin
        if (sh_d >= {1'b0, den}) begin
          dr  <= sh_d - {1'b0, den};
          quo <= {quo[NW-2:0], 1'b1};
        end else begin
          dr  <= sh_d;
          quo <= {quo[NW-2:0], 1'b0};
        end
      end
      cnt <= cnt - 1'b1;
      if (cnt == CW'(1)) busy <= 1'b0;
    end
  end

  assign root = DW'(res);
endmodule
`default_nettype wire

// ===== src/quaternion_orientation_unit.sv =====
// top level: quaternion state, sequencer, shared mac and sqrt/divide unit
// kinds: load and nop build the matrix from the state, multiply first updates the state, normalize
// first runs the bit-serial sqrt and divider, while a zero norm skips them and sets zero_norm
// one item at a time: s_tready is low from acceptance until the result is taken
// the next item can be accepted only after m_tready has been high in the output state
// reset: state goes to the identity quaternion, no result pending
`default_nettype none
module quaternion_orientation_unit #(
  parameter int FRAC_BITS  = qou_pkg::FRAC_BITS_DEF,
  parameter int COMP_WIDTH = qou_pkg::COMP_WIDTH_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [63:0]  s_tdata,   // q_w, q_x, q_y, q_z
  input  wire logic [1:0]   s_tuser,   // kind
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [143:0]      m_tdata,   // m_r0c0 .. m_r2c2
  output logic              m_tuser    // zero_norm
);
  localparam int CW    = COMP_WIDTH;
  localparam int ACC_W = 2 * CW + 4;
  localparam int SW    = 2 * CW + 2;
  localparam int DW    = CW + 1;
  localparam int NW    = CW + FRAC_BITS + 1;
  localparam int ONE   = (FRAC_BITS >= CW - 1) ? (2 ** (CW - 1)) - 1 : 2 ** FRAC_BITS;
  localparam int SMAXW = (SW > 64) ? 64 : SW;
  localparam logic signed [NW:0] QMAX = (NW+1)'((64'sd1 <<< (CW - 1)) - 64'sd1);

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_MAT, S_SQ, S_ROOT, S_DIV, S_DIVW, S_OUT
  } state_t;

  state_t                  state;
  logic signed [CW-1:0]    q [4];
  logic signed [CW-1:0]    b [4];
  logic signed [CW-1:0]    nq [4];
  logic [5:0]              step;
  logic [1:0]              comp;
  logic                    zn;
  logic signed [15:0]      mat [9];
  logic [SW-1:0]           ssum;
  logic [SW-1:0]           s_sat;
  logic [DW-1:0]           nrm;
  logic                    wait1;

  qou_pkg::mac_ctl_t       ctl;
  logic signed [CW-1:0]    ma, mb;
  logic signed [ACC_W-1:0] acc;

  logic                    sqrt_go, div_go, sd_busy;
  logic [NW-1:0]           num, quo;
  logic [DW-1:0]           root;

  qou_mac #(.FRAC_BITS(FRAC_BITS), .COMP_WIDTH(CW), .ACC_W(ACC_W)) u_mac (
    .clk(clk), .ctl(ctl), .a(ma), .b(mb), .acc(acc)
  );

  qou_sqdiv #(.SW(SW), .NW(NW), .DW(DW)) u_sd (
    .clk(clk), .rst(rst), .sqrt_go(sqrt_go), .s_in(s_sat), .div_go(div_go),
    .num(num), .den(nrm), .busy(sd_busy), .root(root), .quo(quo)
  );

  // saturate a 16-bit input field to the component width
  function automatic logic signed [CW-1:0] sat_in(input logic signed [15:0] v);
    logic signed [47:0] e;
    logic signed [47:0] hi;
    e  = 48'(v);
    hi = (48'sd1 <<< (CW - 1)) - 48'sd1;
    if (e > hi) sat_in = CW'(hi);
    else if (e < -hi - 48'sd1) sat_in = CW'(-hi - 48'sd1);
    else sat_in = CW'(e);
  endfunction

  function automatic logic signed [CW-1:0] sat_c(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] hi;
    hi = (ACC_W'(1) <<< (CW - 1)) - ACC_W'(1);
    if (v > hi) sat_c = CW'(hi);
    else if (v < -hi - ACC_W'(1)) sat_c = CW'(-hi - ACC_W'(1));
    else sat_c = CW'(v);
  endfunction

  function automatic logic signed [15:0] sat_o(input logic signed [ACC_W:0] v);
    if (v > (ACC_W+1)'(32767)) sat_o = 16'sh7fff;
    else if (v < -(ACC_W+1)'(32768)) sat_o = 16'sh8000;
    else sat_o = 16'(v);
  endfunction

  // product schedule: for each step, operand indexes and subtract flag
  // multiply: 4 results x 4 terms; matrix: 9 entries x 4 slots (off-diagonal 2 terms)
  // the matrix phase runs the mac slots, then captures the last entry
  logic [1:0] ia, ib;
  logic       sgn, use_b, valid_t;

  always_comb begin
    ia = 2'd0; ib = 2'd0; sgn = 1'b0; use_b = 1'b0; valid_t = 1'b1;
    if (state == S_MUL) begin
      use_b = 1'b1;
      case (step[3:0])
        4'd0:  begin ia = 2'd0; ib = 2'd0; end
        4'd1:  begin ia = 2'd1; ib = 2'd1; sgn = 1'b1; end
        4'd2:  begin ia = 2'd2; ib = 2'd2; sgn = 1'b1; end
        4'd3:  begin ia = 2'd3; ib = 2'd3; sgn = 1'b1; end
        4'd4:  begin ia = 2'd0; ib = 2'd1; end
        4'd5:  begin ia = 2'd1; ib = 2'd0; end
        4'd6:  begin ia = 2'd2; ib = 2'd3; end
        4'd7:  begin ia = 2'd3; ib = 2'd2; sgn = 1'b1; end
        4'd8:  begin ia = 2'd0; ib = 2'd2; end
        4'd9:  begin ia = 2'd1; ib = 2'd3; sgn = 1'b1; end
        4'd10: begin ia = 2'd2; ib = 2'd0; end
        4'd11: begin ia = 2'd3; ib = 2'd1; end
        4'd12: begin ia = 2'd0; ib = 2'd3; end
        4'd13: begin ia = 2'd1; ib = 2'd2; end
        4'd14: begin ia = 2'd2; ib = 2'd1; sgn = 1'b1; end
        default: begin ia = 2'd3; ib = 2'd0; end
      endcase
    end else begin
      case (step)
        6'd0:  begin ia = 2'd0; ib = 2'd0; end
        6'd1:  begin ia = 2'd1; ib = 2'd1; end
        6'd2:  begin ia = 2'd2; ib = 2'd2; sgn = 1'b1; end
        6'd3:  begin ia = 2'd3; ib = 2'd3; sgn = 1'b1; end
        6'd4:  begin ia = 2'd1; ib = 2'd2; end
        6'd5:  begin ia = 2'd0; ib = 2'd3; sgn = 1'b1; end
        6'd8:  begin ia = 2'd1; ib = 2'd3; end
        6'd9:  begin ia = 2'd0; ib = 2'd2; end
        6'd12: begin ia = 2'd1; ib = 2'd2; end
        6'd13: begin ia = 2'd0; ib = 2'd3; end
        6'd16: begin ia = 2'd0; ib = 2'd0; end
        6'd17: begin ia = 2'd1; ib = 2'd1; sgn = 1'b1; end
        6'd18: begin ia = 2'd2; ib = 2'd2; end
        6'd19: begin ia = 2'd3; ib = 2'd3; sgn = 1'b1; end
        6'd20: begin ia = 2'd2; ib = 2'd3; end
        6'd21: begin ia = 2'd0; ib = 2'd1; sgn = 1'b1; end
        6'd24: begin ia = 2'd1; ib = 2'd3; end
        6'd25: begin ia = 2'd0; ib = 2'd2; sgn = 1'b1; end
        6'd28: begin ia = 2'd2; ib = 2'd3; end
        6'd29: begin ia = 2'd0; ib = 2'd1; end
        6'd32: begin ia = 2'd0; ib = 2'd0; end
        6'd33: begin ia = 2'd1; ib = 2'd1; sgn = 1'b1; end
        6'd34: begin ia = 2'd2; ib = 2'd2; sgn = 1'b1; end
        6'd35: begin ia = 2'd3; ib = 2'd3; end
        default: valid_t = 1'b0;
      endcase
    end
  end

  // each sum is captured in the first slot of the next group, while the mac clears
  always_comb begin
    ma = q[ia];
    mb = use_b ? b[ib] : q[ib];
    ctl.start = (state == S_MUL || state == S_MAT) && valid_t;
    ctl.clear = (step[1:0] == 2'd0);
    ctl.sub   = sgn;
  end

  // squared magnitude term and divider numerator for the component selected by comp
  logic [2*CW-1:0] sq;
  always_comb begin
    sq = (2*CW)'($signed(q[comp]) * $signed(q[comp]));
    num = NW'($signed(q[comp])) <<< FRAC_BITS;
    if (q[comp][CW-1]) num = NW'(-$signed(num));
  end

  // sum of squares clamps at 2^64-1, reachable only with the widest components
  always_comb begin
    s_sat = ssum;
    if (SW > 64 && (ssum >> SMAXW) != '0) s_sat = SW'({SMAXW{1'b1}});
  end

  logic signed [NW:0] sq_signed;
  logic signed [ACC_W-1:0] qv;
  always_comb begin
    sq_signed = q[comp][CW-1] ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
    if (sq_signed > QMAX) qv = ACC_W'(QMAX);
    else if (sq_signed < -QMAX - (NW+1)'(1)) qv = ACC_W'(-QMAX - (NW+1)'(1));
    else qv = ACC_W'(sq_signed);
  end

  logic signed [ACC_W:0] acc2;
  assign acc2 = {acc, 1'b0};

  // start pulses for the sqrt/divide unit
  assign sqrt_go = (state == S_ROOT) && wait1 && (ssum != '0);
  assign div_go  = (state == S_DIV);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      s_tready <= 1'b1;
      m_tvalid <= 1'b0;
      q[0] <= CW'(ONE); q[1] <= '0; q[2] <= '0; q[3] <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (s_tvalid && s_tready) begin
            s_tready <= 1'b0;
            zn   <= 1'b0;
            step <= '0;
            b[0] <= sat_in(s_tdata[15:0]);
            b[1] <= sat_in(s_tdata[31:16]);
            b[2] <= sat_in(s_tdata[47:32]);
            b[3] <= sat_in(s_tdata[63:48]);
            case (qou_pkg::kind_t'(s_tuser))
              qou_pkg::KIND_LOAD: begin
                q[0] <= sat_in(s_tdata[15:0]);
                q[1] <= sat_in(s_tdata[31:16]);
                q[2] <= sat_in(s_tdata[47:32]);
                q[3] <= sat_in(s_tdata[63:48]);
                state <= S_MAT;
              end
              qou_pkg::KIND_MUL:  state <= S_MUL;
              qou_pkg::KIND_NORM: begin
                state <= S_SQ; comp <= '0; ssum <= '0;
              end
              default: state <= S_MAT;
            endcase
          end
        end
        S_MUL: begin
          // capture each sum in the cycle after its last term
          step <= (step == 6'd16) ? '0 : step + 6'd1;
          if (step != 6'd0 && step[1:0] == 2'd0) nq[step[3:2] - 2'd1] <= sat_c(acc);
          if (step == 6'd16) begin
            q[0] <= nq[0]; q[1] <= nq[1]; q[2] <= nq[2]; q[3] <= sat_c(acc);
            state <= S_MAT;
          end
        end
        S_MAT: begin
          step <= step + 6'd1;
          if (step != 6'd0 && step[1:0] == 2'd0) begin
            // diagonal entries are plain sums, off-diagonal ones are doubled
            if (step == 6'd4 || step == 6'd20 || step == 6'd36)
              mat[step[5:2] - 4'd1] <= sat_o((ACC_W+1)'(acc));
            else mat[step[5:2] - 4'd1] <= sat_o(acc2);
          end
          if (step == 6'd36) begin
            state    <= S_OUT;
            m_tvalid <= 1'b1;
          end
        end
        S_SQ: begin
          ssum <= ssum + SW'(sq);
          comp <= comp + 2'd1;
          if (comp == 2'd3) begin
            state <= S_ROOT;
            wait1 <= 1'b1;
          end
        end
        S_ROOT: begin
          if (wait1) begin
            wait1 <= 1'b0;
            if (ssum == '0) begin
              zn <= 1'b1; step <= '0; state <= S_MAT;
            end
          end else if (!sd_busy && !sqrt_go) begin
            nrm <= root;
            comp <= '0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          state  <= S_DIVW;
        end
        S_DIVW: begin
          if (!sd_busy && !div_go) begin
            nq[comp] <= sat_c(qv);
            comp <= comp + 2'd1;
            if (comp == 2'd3) begin
              q[0] <= nq[0]; q[1] <= nq[1]; q[2] <= nq[2]; q[3] <= sat_c(qv);
              step <= '0;
              state <= S_MAT;
            end else begin
              state <= S_DIV;
            end
          end
        end
        S_OUT: begin
          if (m_tready) begin
            m_tvalid <= 1'b0;
            s_tready <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < 9; i++) m_tdata[16*i +: 16] = mat[i];
    m_tuser = zn;
  end
endmodule
`default_nettype wire
